// ----- hdl/msq_pkg.sv -----
// ----------------------------------------------------------------------------
// msq_pkg
// Types, codes and fixed widths shared by the step sequencer modules.
// ----------------------------------------------------------------------------
package msq_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TIME_W     = 32;
  localparam int BPM_W      = 10;
  localparam int NOTE_W     = 7;
  localparam int SPEED_W    = 5;
  localparam int RATE_W     = 18;
  localparam int COUNT_W    = 4;
  localparam int POS_W      = 3;
  localparam int TONE_SLOTS = 4;
  localparam int BS_W       = BPM_W + SPEED_W;
  localparam int PROD_W     = TIME_W + BS_W;
  localparam int DIVR_W     = RATE_W + 6;
  localparam int REM_W      = DIVR_W + 1;
  localparam int DCNT_W     = $clog2(PROD_W);
  localparam int MSG_CAP    = 35;
  localparam int MSG_W      = $clog2(MSG_CAP + 1);
  localparam int SECS_PER_MIN = 60;

  localparam logic [NOTE_W-1:0]  NOTE_MAX  = 7'd127;
  localparam logic [SPEED_W-1:0] SPEED_RST = 5'd4;
  localparam logic [RATE_W-1:0]  RATE_RST  = 18'd48000;

  localparam logic KIND_ALL_OFF = 1'b0;
  localparam logic KIND_NOTE_ON = 1'b1;

  typedef enum logic [1:0] {
    ACT_TICK,
    ACT_NOTE_ON,
    ACT_NOTE_OFF,
    ACT_ALL_OFF
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_COUNT,
    CFG_SPEED,
    CFG_RATE,
    CFG_PAT_01,
    CFG_PAT_23,
    CFG_PAT_45,
    CFG_PAT_67
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_WALK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [TIME_W-1:0] track_time;
    logic [BPM_W-1:0]  tempo_bpm;
    logic [NOTE_W-1:0] key_note;
  } in_t;

  typedef struct packed {
    logic              message_kind;
    logic [NOTE_W-1:0] note;
    logic              last;
  } out_t;

  typedef struct packed {
    logic cap_in;
    logic rewind;
    logic note_on;
    logic stop;
    logic mul1;
    logic mul2;
    logic div_step;
    logic step_adv;
    logic emit_start;
    logic emit_tones;
    logic slot_adv;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_note_on;
    logic is_off;
    logic n_zero;
    logic playing;
    logic rate_zero;
    logic div_last;
    logic walk_done;
    logic slot_end;
    logic slot_stall;
  } sts_t;

endpackage

// ----- hdl/msq_ctrl.sv -----
// ----------------------------------------------------------------------------
// msq_ctrl
// Sequencing of one input beat: decode, multiply, divide, step walk, emission.
// ----------------------------------------------------------------------------
module msq_ctrl
  import msq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.n_zero) begin
          state_nxt = ST_IDLE;
        end else if (sts.is_tick) begin
          if (!sts.playing) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.rewind = 1'b1;
            state_nxt  = sts.rate_zero ? ST_IDLE : ST_MUL1;
          end
        end else if (sts.is_note_on) begin
          cmd.note_on    = 1'b1;
          cmd.emit_start = 1'b1;
          cmd.emit_tones = 1'b1;
          state_nxt      = ST_EMIT;
        end else if (sts.is_off) begin
          cmd.stop       = 1'b1;
          cmd.emit_start = 1'b1;
          state_nxt      = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.step_adv = 1'b1;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.slot_end) begin
          state_nxt = sts.is_tick ? ST_WALK : ST_IDLE;
        end else if (!sts.slot_stall) begin
          cmd.slot_adv = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/msq_datapath.sv -----
// ----------------------------------------------------------------------------
// msq_datapath
// Settings, sequencer state, step position divider and output beat register.
// ----------------------------------------------------------------------------
module msq_datapath
  import msq_pkg::*;
#(
  parameter int MAX_STEPS      = 8,
  parameter int TONES_PER_STEP = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_t                   in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  localparam int SLOT_W  = $clog2(TONES_PER_STEP + 2);
  localparam int GUARD_W = $clog2(MAX_STEPS + 1);
  localparam logic [COUNT_W-1:0] MAX_CNT  = COUNT_W'(MAX_STEPS);
  localparam logic [SLOT_W-1:0]  SLOT_END = SLOT_W'(TONES_PER_STEP + 1);
  localparam logic [GUARD_W-1:0] GUARD_MAX = GUARD_W'(MAX_STEPS);

  // settings
  logic [COUNT_W-1:0]    step_count_r;
  logic [SPEED_W-1:0]    speed_r;
  logic [RATE_W-1:0]     rate_r;
  logic [CFG_DATA_W-1:0] pat_r [4];

  // sequencer state
  logic [POS_W-1:0]  pos_r;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] latest_r;
  logic              playing_r;
  logic              has_base_r;
  logic [NOTE_W-1:0] base_r;

  // job and arithmetic
  in_t                in_r;
  logic [BS_W-1:0]    bs_r;
  logic [TIME_W-1:0]  diff_r;
  logic [DIVR_W-1:0]  divr_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DIVR_W-1:0]  rem_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [COUNT_W-1:0] qmod_r;
  logic [GUARD_W-1:0] guard_r;
  logic               final_r;
  logic               tones_en_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [MSG_W-1:0]   count_r;
  logic               out_valid_r;
  out_t               out_r;

  logic [COUNT_W-1:0]    n_steps;
  logic                  key_match;
  logic [31:0]           word;
  logic [TONE_SLOTS-1:0] tone_v;
  logic                  later;
  logic [1:0]            tone_idx;
  logic [NOTE_W-1:0]     offset;
  logic [NOTE_W:0]       sum;
  logic                  msg_exists;
  logic                  emit_ok;
  logic                  load;
  out_t                  msg;
  logic                  out_free;
  logic [COUNT_W-1:0]    pos_inc;
  logic [POS_W-1:0]      pos_nxt;
  logic [GUARD_W-1:0]    guard_nxt;
  logic                  final_nxt;
  logic                  dbit;
  logic [REM_W-1:0]      rem_sh;
  logic                  qbit;
  logic [DIVR_W-1:0]     rem_nxt;
  logic [COUNT_W-1:0]    qt;
  logic [COUNT_W-1:0]    qmod_nxt;

  assign n_steps   = (step_count_r > MAX_CNT) ? MAX_CNT : step_count_r;
  assign key_match = has_base_r && (base_r == in_r.key_note);
  assign word      = pos_r[0] ? pat_r[pos_r[2:1]][63:32] : pat_r[pos_r[2:1]][31:0];

  // tone emission
  always_comb begin
    later = 1'b0;
    for (int j = 0; j < TONE_SLOTS; j++) begin
      tone_v[j] = word[8*j+7] && tones_en_r && (j < TONES_PER_STEP);
    end
    for (int j = 0; j < TONE_SLOTS; j++) begin
      if (tone_v[j] && (j >= int'(slot_r))) begin
        later = 1'b1;
      end
    end
  end

  assign tone_idx   = 2'(slot_r - SLOT_W'(1));
  assign offset     = word[8*tone_idx +: NOTE_W];
  assign sum        = {1'b0, base_r} + {1'b0, offset};
  assign msg_exists = (slot_r == '0) || tone_v[tone_idx];
  assign emit_ok    = msg_exists && (count_r != MSG_W'(MSG_CAP));
  assign out_free   = !out_valid_r || out_ready;
  assign load       = cmd.slot_adv && emit_ok;

  always_comb begin
    msg.message_kind = (slot_r == '0) ? KIND_ALL_OFF : KIND_NOTE_ON;
    msg.note         = (slot_r == '0) ? '0 : (sum[NOTE_W] ? NOTE_MAX : sum[NOTE_W-1:0]);
    msg.last         = (count_r == MSG_W'(MSG_CAP - 1)) || (final_r && !later);
  end

  // step walk
  assign pos_inc   = {1'b0, pos_r} + COUNT_W'(1);
  assign pos_nxt   = (pos_inc >= n_steps) ? '0 : pos_inc[POS_W-1:0];
  assign guard_nxt = guard_r + GUARD_W'(1);
  assign final_nxt = ({1'b0, pos_nxt} == qmod_r) || (guard_nxt == GUARD_MAX);

  // restoring divide, quotient reduced modulo the step count on the fly
  assign dbit     = prod_r[dcnt_r];
  assign rem_sh   = {rem_r, dbit};
  assign qbit     = rem_sh >= {1'b0, divr_r};
  assign rem_nxt  = qbit ? DIVR_W'(rem_sh - {1'b0, divr_r}) : rem_sh[DIVR_W-1:0];
  assign qt       = {qmod_r[COUNT_W-2:0], qbit};
  assign qmod_nxt = (qt >= n_steps) ? (qt - n_steps) : qt;

  always_comb begin
    sts.is_tick    = in_r.action == ACT_TICK;
    sts.is_note_on = in_r.action == ACT_NOTE_ON;
    sts.is_off     = ((in_r.action == ACT_NOTE_OFF) && key_match) ||
                     (in_r.action == ACT_ALL_OFF);
    sts.n_zero     = n_steps == '0;
    sts.playing    = playing_r;
    sts.rate_zero  = rate_r == '0;
    sts.div_last   = dcnt_r == '0;
    sts.walk_done  = ({1'b0, pos_r} == qmod_r) || (guard_r == GUARD_MAX);
    sts.slot_end   = slot_r == SLOT_END;
    sts.slot_stall = emit_ok && !out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= '0;
      speed_r      <= SPEED_RST;
      rate_r       <= RATE_RST;
      for (int i = 0; i < 4; i++) begin
        pat_r[i] <= '0;
      end
      pos_r       <= '0;
      start_r     <= '0;
      latest_r    <= '0;
      playing_r   <= 1'b0;
      has_base_r  <= 1'b0;
      base_r      <= '0;
      guard_r     <= '0;
      final_r     <= 1'b0;
      tones_en_r  <= 1'b0;
      slot_r      <= SLOT_END;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_COUNT: step_count_r <= cfg_data[COUNT_W-1:0];
          CFG_SPEED:      speed_r      <= cfg_data[SPEED_W-1:0];
          CFG_RATE:       rate_r       <= cfg_data[RATE_W-1:0];
          CFG_PAT_01:     pat_r[0]     <= cfg_data;
          CFG_PAT_23:     pat_r[1]     <= cfg_data;
          CFG_PAT_45:     pat_r[2]     <= cfg_data;
          CFG_PAT_67:     pat_r[3]     <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.cap_in) begin
        if (in_data.action == ACT_TICK) begin
          latest_r <= in_data.track_time;
        end
        count_r <= '0;
        guard_r <= '0;
      end
      if (cmd.rewind && (in_r.track_time < start_r)) begin
        start_r <= in_r.track_time;
        pos_r   <= '0;
      end
      if (cmd.note_on) begin
        if (!has_base_r) begin
          pos_r   <= '0;
          start_r <= latest_r;
        end
        playing_r  <= 1'b1;
        has_base_r <= 1'b1;
        base_r     <= in_r.key_note;
      end
      if (cmd.stop) begin
        playing_r <= 1'b0;
      end
      if (cmd.emit_start) begin
        slot_r     <= '0;
        final_r    <= 1'b1;
        tones_en_r <= cmd.emit_tones;
      end
      if (cmd.step_adv) begin
        pos_r      <= pos_nxt;
        guard_r    <= guard_nxt;
        final_r    <= final_nxt;
        tones_en_r <= 1'b1;
        slot_r     <= '0;
      end
      if (cmd.slot_adv) begin
        slot_r <= slot_r + SLOT_W'(1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
        count_r     <= count_r + MSG_W'(1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_r <= in_data;
    end
    if (cmd.mul1) begin
      bs_r   <= BS_W'(in_r.tempo_bpm) * BS_W'(speed_r);
      diff_r <= in_r.track_time - start_r;
      divr_r <= DIVR_W'(rate_r) * DIVR_W'(SECS_PER_MIN);
    end
    if (cmd.mul2) begin
      prod_r <= PROD_W'(diff_r) * PROD_W'(bs_r);
      rem_r  <= '0;
      qmod_r <= '0;
      dcnt_r <= DCNT_W'(PROD_W - 1);
    end
    if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      qmod_r <= qmod_nxt;
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
    if (load) begin
      out_r <= msg;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("output beat overwritten");

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MSG_W'(MSG_CAP))
    else $error("message count above cap");

  assert property (@(posedge clk) disable iff (!rst_n)
    guard_r <= GUARD_MAX)
    else $error("step walk ran past its guard");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && (dcnt_r == '0)) |=> (qmod_r < n_steps))
    else $error("target step not below step count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.message_kind == KIND_ALL_OFF)) |-> (out_r.note == '0))
    else $error("all-off beat carries a note");
`endif

endmodule

// ----- hdl/midi_step_sequencer.sv -----
// ----------------------------------------------------------------------------
// midi_step_sequencer
// Step sequencer and arpeggiator: tick, note on, note off and all-off beats
// in, all-off and note-on messages out.
// ----------------------------------------------------------------------------
// One input beat is taken at a time, only while the controller is idle.
// A note on, a matching note off or an all off is decoded and then emits its
// messages; a note off that matches no held note ends after decode. A tick that
// advances is decoded, multiplied in two states and then runs a bit-serial
// divide of elapsed * tempo * speed by the rate register * 60, then walks one
// step at a time, emitting the messages of each step, up to MAX_STEPS steps;
// a tick that does not advance ends after decode or after the divide. Each
// message waits in a single output register, so a stalled out_ready holds
// emission. Settings are written on the cfg port (always ready) and must only
// change while idle.
// ----------------------------------------------------------------------------
module midi_step_sequencer
  import msq_pkg::*;
#(
  parameter int MAX_STEPS      = 8,
  parameter int TONES_PER_STEP = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  msq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  msq_datapath #(
    .MAX_STEPS      (MAX_STEPS),
    .TONES_PER_STEP (TONES_PER_STEP)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
